// ===== src/svm_pkg.sv =====
// shared types and constants for the stereo voice mixer
`timescale 1ns / 1ps
`default_nettype none

package svm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int VOL_W     = 16;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 38;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // register index lives in paddr[2]
    localparam int  REG_IDX_LSB = 2;
    localparam logic REG_MUTE   = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [VOL_W-1:0]    volume_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [PROD_W:0]     mul_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    localparam sum_t ROUND_BIAS = sum_t'((1 << FRAC_BITS) - 1);
    localparam sum_t SAT_MAX    = sum_t'(32767);
    localparam sum_t SAT_MIN    = sum_t'(-32768);

endpackage

`default_nettype wire

// ===== src/svm_round_sat.sv =====
// scales a frame sum down by the volume fraction, truncating toward zero, and saturates
`timescale 1ns / 1ps
`default_nettype none

module svm_round_sat
(
    input  var svm_pkg::sum_t    sum,
    output var svm_pkg::sample_t result,
    output logic                 clip
);
    import svm_pkg::*;

    sum_t biased;
    sum_t quot;

    // negative sums get a bias so the arithmetic shift rounds toward zero
    assign biased = sum + (sum[SUM_W-1] ? ROUND_BIAS : '0);
    assign quot   = biased >>> FRAC_BITS;

    always_comb
    begin
        if (quot > SAT_MAX)
        begin
            result = sample_t'(SAT_MAX);
            clip   = 1'b1;
        end
        else if (quot < SAT_MIN)
        begin
            result = sample_t'(SAT_MIN);
            clip   = 1'b1;
        end
        else
        begin
            result = quot[SAMPLE_W-1:0];
            clip   = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== src/stereo_voice_mixer_top.sv =====
// top level of the stereo voice mixer: input, multiply, accumulate and output stages
//
// channel   | dir | transfer                | payload
// ----------+-----+-------------------------+--------------------------------------
// s_axis    | in  | one voice of a frame    | samples, volume; mono/active; last
// m_axis    | out | one mixed stereo frame  | left/right samples; clipped
// apb       | in  | register access         | mute at address 0
//
// one voice transfer is accepted per cycle, back to back, unless a stall backs up to the input
// after its last voice is accepted, a frame passes the multiply, accumulate and output registers
// the datapath uses two 16x17 multipliers and two 38-bit accumulators
// reset clears all stage valids, both accumulators and mute
// a stall on m_axis backs up stage by stage; non-last voices keep flowing past a full output
`timescale 1ns / 1ps
`default_nettype none

module stereo_voice_mixer_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // left_sample, right_sample, volume
    input  logic [1:0]  s_axis_tuser,   // is_mono, voice_active
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_left, out_right
    output logic [0:0]  m_axis_tuser,   // clipped

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [svm_pkg::ADDR_W-1:0] paddr,
    input  logic [svm_pkg::DATA_W-1:0] pwdata,
    output logic [svm_pkg::DATA_W-1:0] prdata,
    output logic                      pready
);
    import svm_pkg::*;

    logic mute_reg;

    logic    a_valid_reg;
    sample_t a_left_reg;
    sample_t a_right_reg;
    volume_t a_vol_reg;
    logic    a_mono_reg;
    logic    a_active_reg;
    logic    a_last_reg;

    logic  b_valid_reg;
    prod_t b_prod_l_reg;
    prod_t b_prod_r_reg;
    logic  b_last_reg;
    logic  b_mute_reg;

    sum_t acc_l_reg;
    sum_t acc_r_reg;

    logic c_valid_reg;
    sum_t c_sum_l_reg;
    sum_t c_sum_r_reg;
    logic c_mute_reg;

    logic    out_valid_reg;
    sample_t out_left_reg;
    sample_t out_right_reg;
    logic    out_clip_reg;

    logic d_free;
    logic c_move;
    logic c_free;
    logic b_fire;
    logic b_free;
    logic a_move;
    logic a_free;
    logic s_fire;
    logic cfg_write;

    sample_t              mul_r_src;
    logic signed [PROD_W:0] mul_l;
    logic signed [PROD_W:0] mul_r;
    logic                 add_en;
    prod_t                prod_l_next;
    prod_t                prod_r_next;
    sum_t                 acc_l_next;
    sum_t                 acc_r_next;

    sample_t fin_left;
    sample_t fin_right;
    logic    fin_clip_l;
    logic    fin_clip_r;

    // stage handshakes
    assign d_free = !out_valid_reg || m_axis_tready;
    assign c_move = c_valid_reg && d_free;
    assign c_free = !c_valid_reg || d_free;
    assign b_fire = b_valid_reg && (!b_last_reg || c_free);
    assign b_free = !b_valid_reg || b_fire;
    assign a_move = a_valid_reg && b_free;
    assign a_free = !a_valid_reg || b_free;
    assign s_fire = s_axis_tvalid && a_free;

    assign s_axis_tready = a_free;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {{(DATA_W-1){1'b0}}, mute_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[REG_IDX_LSB] == REG_MUTE))
        begin
            mute_reg <= pwdata[0];
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_left_reg   <= s_axis_tdata[15:0];
            a_right_reg  <= s_axis_tdata[31:16];
            a_vol_reg    <= s_axis_tdata[47:32];
            a_mono_reg   <= s_axis_tuser[0];
            a_active_reg <= s_axis_tuser[1];
            a_last_reg   <= s_axis_tlast;
        end
    end

    // multiply stage, mono voices reuse the left sample
    assign mul_r_src   = a_mono_reg ? a_left_reg : a_right_reg;
    assign mul_l       = mul_t'(a_left_reg) * mul_t'({1'b0, a_vol_reg});
    assign mul_r       = mul_t'(mul_r_src) * mul_t'({1'b0, a_vol_reg});
    assign add_en      = a_active_reg && !mute_reg;
    assign prod_l_next = add_en ? mul_l[PROD_W-1:0] : '0;
    assign prod_r_next = add_en ? mul_r[PROD_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_free)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_prod_l_reg <= prod_l_next;
            b_prod_r_reg <= prod_r_next;
            b_last_reg   <= a_last_reg;
            b_mute_reg   <= mute_reg;
        end
    end

    // accumulate stage
    assign acc_l_next = acc_l_reg + sum_t'(b_prod_l_reg);
    assign acc_r_next = acc_r_reg + sum_t'(b_prod_r_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (b_fire)
        begin
            if (b_last_reg)
            begin
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            else
            begin
                acc_l_reg <= acc_l_next;
                acc_r_reg <= acc_r_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= b_fire && b_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_last_reg)
        begin
            c_sum_l_reg <= acc_l_next;
            c_sum_r_reg <= acc_r_next;
            c_mute_reg  <= b_mute_reg;
        end
    end

    // scale and saturate
    svm_round_sat u_sat_l
    (
        .sum    (c_sum_l_reg),
        .result (fin_left),
        .clip   (fin_clip_l)
    );

    svm_round_sat u_sat_r
    (
        .sum    (c_sum_r_reg),
        .result (fin_right),
        .clip   (fin_clip_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (d_free)
        begin
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_move)
        begin
            out_left_reg  <= c_mute_reg ? '0 : fin_left;
            out_right_reg <= c_mute_reg ? '0 : fin_right;
            out_clip_reg  <= !c_mute_reg && (fin_clip_l || fin_clip_r);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_right_reg, out_left_reg};
    assign m_axis_tuser  = out_clip_reg;

`ifndef SYNTHESIS
    a_clear_after_frame : assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_last_reg) |=> (acc_l_reg == '0 && acc_r_reg == '0))
        else $error("accumulators not cleared after frame end");

    a_frame_held : assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !d_free) |=> (c_valid_reg && $stable(c_sum_l_reg)
                                      && $stable(c_sum_r_reg)))
        else $error("pending frame sum lost during output stall");

    a_clip_saturated : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clip_reg) |->
            (out_left_reg == sample_t'(SAT_MAX) || out_left_reg == sample_t'(SAT_MIN)
             || out_right_reg == sample_t'(SAT_MAX) || out_right_reg == sample_t'(SAT_MIN)))
        else $error("clip flag set without a saturated channel");
`endif

endmodule

`default_nettype wire

// ===== verif/svm_frame_checker.sv =====
// frame checker for the stereo voice mixer: predicts every mixed frame and compares it
`timescale 1ns / 1ps

module svm_frame_checker
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [47:0]                s_axis_tdata,   // left_sample, right_sample, volume
    input  logic [1:0]                 s_axis_tuser,   // is_mono, voice_active
    input  logic                       s_axis_tlast,

    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [31:0]                m_axis_tdata,   // out_left, out_right
    input  logic [0:0]                 m_axis_tuser,   // clipped

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [svm_pkg::ADDR_W-1:0] paddr,
    input  logic [svm_pkg::DATA_W-1:0] pwdata,

    output int                         mismatches,
    output int                         frames_pending,
    output int                         frames_checked
);

    import svm_pkg::*;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    clipped;
    } frame_t;

    sum_t   left_acc;
    sum_t   right_acc;
    logic   muted;
    frame_t frame_q[$];
    frame_t want;

    function automatic sample_t settle(input sum_t acc, inout logic clip);
        longint q;
        q = longint'(acc) / (longint'(1) << FRAC_BITS);
        if (q > longint'(SAT_MAX))
        begin
            q    = longint'(SAT_MAX);
            clip = 1'b1;
        end
        else if (q < longint'(SAT_MIN))
        begin
            q    = longint'(SAT_MIN);
            clip = 1'b1;
        end
        return sample_t'(q);
    endfunction

    task automatic mix_voice(input logic [47:0] data, input logic [1:0] flags,
                             input logic last);
        sample_t ls;
        sample_t rs;
        volume_t vol;
        longint  pl;
        longint  pr;
        frame_t  f;
        ls  = data[15:0];
        rs  = data[31:16];
        vol = data[47:32];
        if (!muted && flags[1])
        begin
            pl        = longint'(ls) * longint'(vol);
            pr        = flags[0] ? pl : longint'(rs) * longint'(vol);
            left_acc  = left_acc + sum_t'(pl);
            right_acc = right_acc + sum_t'(pr);
        end
        if (last)
        begin
            f.clipped = 1'b0;
            if (muted)
            begin
                f.left  = '0;
                f.right = '0;
            end
            else
            begin
                f.left  = settle(left_acc, f.clipped);
                f.right = settle(right_acc, f.clipped);
            end
            frame_q.push_back(f);
            left_acc  = '0;
            right_acc = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_acc       = '0;
            right_acc      = '0;
            muted          = 1'b0;
            frame_q.delete();
            mismatches     = 0;
            frames_pending = 0;
            frames_checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[REG_IDX_LSB] == REG_MUTE)
                muted = pwdata[0];

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (frame_q.size() == 0)
                begin
                    $error("frame transfer with nothing expected: out_left %0d out_right %0d",
                           $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
                    mismatches++;
                end
                else
                begin
                    want = frame_q.pop_front();
                    frames_checked++;
                    if (m_axis_tdata[15:0] !== want.left)
                    begin
                        $error("out_left: expected %0d, got %0d",
                               want.left, $signed(m_axis_tdata[15:0]));
                        mismatches++;
                    end
                    if (m_axis_tdata[31:16] !== want.right)
                    begin
                        $error("out_right: expected %0d, got %0d",
                               want.right, $signed(m_axis_tdata[31:16]));
                        mismatches++;
                    end
                    if (m_axis_tuser[0] !== want.clipped)
                    begin
                        $error("clipped: expected %0b, got %0b", want.clipped, m_axis_tuser[0]);
                        mismatches++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                mix_voice(s_axis_tdata, s_axis_tuser, s_axis_tlast);

            frames_pending = frame_q.size();
        end
    end

endmodule

// ===== verif/tb_stereo_voice_mixer_top.sv =====
// testbench top for the stereo voice mixer: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_stereo_voice_mixer_top;

    import svm_pkg::*;

    localparam int      CYCLE_LIMIT   = 400000;
    localparam int      SETTLE_CYCLES = 8;
    localparam int      HOLD_CYCLES   = 300;
    localparam int      MAX_VOICES    = 16;
    localparam int      PHASE_VOICES  = 90;
    localparam volume_t UNITY         = volume_t'(1 << FRAC_BITS);
    localparam volume_t VOL_MAX       = 16'hFFFF;
    localparam sample_t PCM_MAX       = 16'sh7FFF;
    localparam sample_t PCM_MIN       = -16'sh8000;

    localparam logic [ADDR_W-1:0] ADDR_MUTE  = ADDR_W'(REG_MUTE) << REG_IDX_LSB;
    localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_W'(1) << REG_IDX_LSB;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata;   // left_sample, right_sample, volume
    logic [1:0]         s_axis_tuser;   // is_mono, voice_active
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [31:0]        m_axis_tdata;   // out_left, out_right
    logic [0:0]         m_axis_tuser;   // clipped
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int   mismatches;
    int   frames_pending;
    int   frames_checked;
    int   voices_sent;
    int   cycle_count;
    int   src_idle_pct;
    int   sink_stall_pct;
    logic hold_req;

    stereo_voice_mixer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    svm_frame_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatches     (mismatches),
        .frames_pending (frames_pending),
        .frames_checked (frames_checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // output side: random stalls, or a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(9))
            0:       return PCM_MAX;
            1:       return PCM_MIN;
            2:       return sample_t'($signed($urandom_range(64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic volume_t rand_volume();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VOL_MAX;
            2:       return UNITY;
            3:       return volume_t'($urandom_range(2 * UNITY));
            default: return volume_t'($urandom);
        endcase
    endfunction

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_voice(input sample_t ls, input sample_t rs, input logic mono,
                              input volume_t vol, input logic active, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vol, rs, ls};
        s_axis_tuser  <= {active, mono};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        voices_sent++;
    endtask

    task automatic send_random_frame();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_VOICES) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            send_voice(rand_sample(), rand_sample(), $urandom_range(9) < 3, rand_volume(),
                       $urandom_range(9) != 0, i == n - 1);
    endtask

    // stop offering voices until every frame is out and the pipeline is empty
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (frames_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int target;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        s_axis_tlast   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        voices_sent    = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        reg_write(ADDR_MUTE, 32'(0));

        send_voice(16'sd1000, -16'sd1000, 1'b0, UNITY, 1'b1, 1'b1);
        send_voice(-16'sd5, 16'sd12345, 1'b1, UNITY, 1'b1, 1'b1);
        // fractions truncate toward zero on both signs
        send_voice(-16'sd1, 16'sd1, 1'b0, 16'd1, 1'b1, 1'b0);
        send_voice(16'sd3, -16'sd3, 1'b0, volume_t'(UNITY / 2), 1'b1, 1'b1);
        send_voice(PCM_MAX, PCM_MIN, 1'b0, VOL_MAX, 1'b1, 1'b1);
        send_voice(PCM_MIN, PCM_MAX, 1'b1, VOL_MAX, 1'b1, 1'b1);
        send_voice(16'sd12000, -16'sd7000, 1'b0, '0, 1'b1, 1'b1);
        // inactive last voice still closes the frame
        send_voice(16'sd500, 16'sd600, 1'b0, UNITY, 1'b1, 1'b0);
        send_voice(PCM_MAX, PCM_MAX, 1'b0, VOL_MAX, 1'b0, 1'b1);
        send_voice(PCM_MIN, PCM_MIN, 1'b1, VOL_MAX, 1'b0, 1'b1);
        send_voice(16'sd16000, -16'sd16000, 1'b0, volume_t'(2 * UNITY), 1'b1, 1'b0);
        send_voice(16'sd16000, -16'sd16000, 1'b0, volume_t'(2 * UNITY), 1'b1, 1'b0);
        send_voice(PCM_MIN, PCM_MAX, 1'b0, volume_t'(3 * UNITY), 1'b1, 1'b0);
        send_voice(16'sd1, -16'sd1, 1'b1, VOL_MAX, 1'b1, 1'b1);

        // partial sums gathered before mute are dropped at the muted frame end
        send_voice(16'sd1234, -16'sd4321, 1'b0, UNITY, 1'b1, 1'b0);
        send_voice(16'sd2222, 16'sd3333, 1'b1, VOL_MAX, 1'b1, 1'b0);
        drain();
        reg_write(ADDR_MUTE, 32'(1));
        send_voice(PCM_MAX, PCM_MIN, 1'b0, VOL_MAX, 1'b1, 1'b1);
        send_voice(16'sd100, 16'sd200, 1'b0, UNITY, 1'b1, 1'b0);
        send_voice(16'sd300, 16'sd400, 1'b1, UNITY, 1'b1, 1'b1);
        drain();
        reg_write(ADDR_SPARE, 32'(0));
        send_voice(16'sd777, -16'sd777, 1'b0, UNITY, 1'b1, 1'b1);
        drain();
        reg_write(ADDR_MUTE, 32'(0));
        send_voice(16'sd777, -16'sd777, 1'b0, UNITY, 1'b1, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 87;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 87;
                end
                default:
                begin
                    src_idle_pct   = 25;
                    sink_stall_pct = 25;
                end
            endcase
            reg_write(ADDR_MUTE, 32'(ph == 2));
            target = voices_sent + PHASE_VOICES;
            while (voices_sent < target)
                send_random_frame();

            if (ph == 0)
            begin
                // long frame that wraps both accumulators
                for (int i = 0; i < 70; i++)
                    send_voice(PCM_MAX, PCM_MIN, 1'b0, VOL_MAX, 1'b1, i == 69);
                // output held off while single-voice frames pile up
                hold_req = 1'b1;
                for (int i = 0; i < 40; i++)
                    send_voice(rand_sample(), rand_sample(), 1'($urandom_range(1)),
                               rand_volume(), 1'b1, 1'b1);
            end
            drain();
        end

        $display("mixed %0d voices into %0d checked frames: mono and stereo, clipping, wrap,",
                 voices_sent, frames_checked);
        $display("inactive and empty frames, mute on and off, output hold-off and stalls");
        if (mismatches == 0 && frames_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
